FILE: hdl/lpd_pkg.sv
// Shared types and constants for the long-press detector.
`default_nettype none
package lpd_pkg;

    // Field widths fixed by the event and result formats.
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned HELD_W   = 17;
    localparam int unsigned SUM_W    = 18;
    localparam int unsigned AMOUNT_W = 18;

    // Event kinds as they arrive on the input channel.
    localparam logic [FUNC_W-1:0] FUNC_PRESS   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOVE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LEAVE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED   = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] HOLD_TIME_RESET = 16'd2000;
    localparam logic [CFG_W-1:0] ALLOWED_RESET   = 16'd160;

    // Recognizer phases.
    typedef enum logic [PHASE_W-1:0] {
        PH_POSSIBLE = 3'd0,
        PH_BEGAN    = 3'd1,
        PH_CHANGED  = 3'd2,
        PH_ENDED    = 3'd3,
        PH_FAILED   = 3'd4
    } phase_t;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_PRESS   = 3'd1,
        OP_MOVE    = 3'd2,
        OP_RELEASE = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    // One queued command: the operation and its amount (motion or time).
    typedef struct packed {
        op_t                 op;
        logic [AMOUNT_W-1:0] amount;
    } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/lpd_front.sv
// Front end: classifies each event and computes its motion or time amount.
`default_nettype none
module lpd_front (
    input  wire logic [lpd_pkg::FUNC_W-1:0]  func,
    input  wire logic                        is_left_button,
    input  wire logic [lpd_pkg::DELTA_W-1:0] move_dx,
    input  wire logic [lpd_pkg::DELTA_W-1:0] move_dy,
    input  wire logic [lpd_pkg::TIME_W-1:0]  elapsed_ms,
    output lpd_pkg::cmd_t                    cmd
);

    logic [lpd_pkg::DELTA_W:0] sx;
    logic [lpd_pkg::DELTA_W:0] sy;
    logic [lpd_pkg::DELTA_W:0] ax;
    logic [lpd_pkg::DELTA_W:0] ay;
    logic [lpd_pkg::AMOUNT_W-1:0] motion;

    // Magnitudes of the signed deltas, one bit wider so that the magnitude of -32768 fits.
    assign sx = {move_dx[lpd_pkg::DELTA_W-1], move_dx};
    assign sy = {move_dy[lpd_pkg::DELTA_W-1], move_dy};
    assign ax = sx[lpd_pkg::DELTA_W] ? (~sx + 17'd1) : sx;
    assign ay = sy[lpd_pkg::DELTA_W] ? (~sy + 17'd1) : sy;
    assign motion = {1'b0, ax} + {1'b0, ay};

    // Classify the event; non-left presses and unknown kinds do nothing.
    always_comb
    begin
        cmd.op     = lpd_pkg::OP_NONE;
        cmd.amount = '0;
        unique case (func)
            lpd_pkg::FUNC_PRESS:
            begin
                if (is_left_button)
                begin
                    cmd.op = lpd_pkg::OP_PRESS;
                end
            end
            lpd_pkg::FUNC_MOVE:
            begin
                cmd.op     = lpd_pkg::OP_MOVE;
                cmd.amount = motion;
            end
            lpd_pkg::FUNC_RELEASE, lpd_pkg::FUNC_LEAVE:
            begin
                cmd.op = lpd_pkg::OP_RELEASE;
            end
            lpd_pkg::FUNC_TICK:
            begin
                cmd.op     = lpd_pkg::OP_TICK;
                cmd.amount = {2'b00, elapsed_ms};
            end
            default:
            begin
                cmd.op = lpd_pkg::OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/lpd_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none
module lpd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire lpd_pkg::cmd_t push_cmd,
    output logic              not_full,
    input  wire logic         pop,
    output logic              not_empty,
    output lpd_pkg::cmd_t     head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    lpd_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/lpd_back.sv
// Back end: recognizer state update and registered result.
`default_nettype none
module lpd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire lpd_pkg::cmd_t               cmd,
    output logic                             cmd_pop,
    input  wire logic [lpd_pkg::CFG_W-1:0]   hold_time_ms,
    input  wire logic [lpd_pkg::CFG_W-1:0]   allowed_motion,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             handled,
    output logic                             fired,
    output logic [lpd_pkg::PHASE_W-1:0]      fired_phase,
    output logic                             moving,
    output logic [lpd_pkg::PHASE_W-1:0]      phase_now
);

    logic                         armed_reg;
    logic                         armed_next;
    logic [lpd_pkg::HELD_W-1:0]   held_reg;
    logic [lpd_pkg::HELD_W-1:0]   held_next;
    logic [lpd_pkg::SUM_W-1:0]    sum_reg;
    logic [lpd_pkg::SUM_W-1:0]    sum_next;
    lpd_pkg::phase_t              phase_reg;
    lpd_pkg::phase_t              phase_next;
    logic                         in_move_reg;
    logic                         in_move_next;
    logic                         out_valid_reg;
    logic                         fired_reg;
    logic                         fired_next;
    lpd_pkg::phase_t              fired_phase_reg;
    lpd_pkg::phase_t              fired_phase_next;

    logic                         active;
    logic [lpd_pkg::SUM_W:0]      sum_add;
    logic [lpd_pkg::SUM_W-1:0]    sum_sat;
    logic [lpd_pkg::HELD_W:0]     held_add;
    logic [lpd_pkg::HELD_W-1:0]   held_sat;

    // A new command is taken whenever the result register is free or drains.
    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    assign active = (phase_reg == lpd_pkg::PH_BEGAN) || (phase_reg == lpd_pkg::PH_CHANGED);

    // Saturating accumulators for motion and hold time.
    assign sum_add  = {1'b0, sum_reg} + {1'b0, cmd.amount};
    assign sum_sat  = sum_add[lpd_pkg::SUM_W] ? '1 : sum_add[lpd_pkg::SUM_W-1:0];
    assign held_add = {1'b0, held_reg} + {2'b00, cmd.amount[lpd_pkg::TIME_W-1:0]};
    assign held_sat = held_add[lpd_pkg::HELD_W] ? '1 : held_add[lpd_pkg::HELD_W-1:0];

    // Next state and result for the command at the queue head.
    always_comb
    begin
        armed_next       = armed_reg;
        held_next        = held_reg;
        sum_next         = sum_reg;
        phase_next       = phase_reg;
        in_move_next     = in_move_reg;
        fired_next       = 1'b0;
        fired_phase_next = lpd_pkg::PH_POSSIBLE;
        unique case (cmd.op)
            lpd_pkg::OP_PRESS:
            begin
                armed_next   = 1'b1;
                held_next    = '0;
                sum_next     = '0;
                in_move_next = 1'b0;
                phase_next   = lpd_pkg::PH_POSSIBLE;
            end
            lpd_pkg::OP_MOVE:
            begin
                if (armed_reg || active)
                begin
                    sum_next = sum_sat;
                    if (active)
                    begin
                        phase_next       = lpd_pkg::PH_CHANGED;
                        in_move_next     = 1'b1;
                        fired_next       = 1'b1;
                        fired_phase_next = lpd_pkg::PH_CHANGED;
                    end
                    else if (sum_sat > {2'b00, allowed_motion})
                    begin
                        armed_next = 1'b0;
                        held_next  = '0;
                        phase_next = lpd_pkg::PH_FAILED;
                    end
                end
            end
            lpd_pkg::OP_RELEASE:
            begin
                armed_next = 1'b0;
                held_next  = '0;
                phase_next = lpd_pkg::PH_POSSIBLE;
                if (active)
                begin
                    in_move_next     = 1'b0;
                    fired_next       = 1'b1;
                    fired_phase_next = lpd_pkg::PH_ENDED;
                end
            end
            lpd_pkg::OP_TICK:
            begin
                if (armed_reg && (phase_reg == lpd_pkg::PH_POSSIBLE))
                begin
                    held_next = held_sat;
                    if (held_sat >= {1'b0, hold_time_ms})
                    begin
                        armed_next       = 1'b0;
                        held_next        = '0;
                        phase_next       = lpd_pkg::PH_BEGAN;
                        fired_next       = 1'b1;
                        fired_phase_next = lpd_pkg::PH_BEGAN;
                    end
                end
            end
            default:
            begin
                fired_next = 1'b0;
            end
        endcase
    end

    // Recognizer state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            held_reg        <= '0;
            sum_reg         <= '0;
            phase_reg       <= lpd_pkg::PH_POSSIBLE;
            in_move_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            fired_reg       <= 1'b0;
            fired_phase_reg <= lpd_pkg::PH_POSSIBLE;
        end
        else
        begin
            if (cmd_pop)
            begin
                armed_reg       <= armed_next;
                held_reg        <= held_next;
                sum_reg         <= sum_next;
                phase_reg       <= phase_next;
                in_move_reg     <= in_move_next;
                fired_reg       <= fired_next;
                fired_phase_reg <= fired_phase_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign handled     = fired_reg;
    assign fired       = fired_reg;
    assign fired_phase = fired_phase_reg;
    assign moving      = in_move_reg;
    assign phase_now   = phase_reg;

endmodule
`default_nettype wire

FILE: hdl/long_press_detector_top.sv
// Top level of the long-press detector: front end, command queue and back end.
//
// The detector takes one event per clock while its queue is not full (press, move, release
// or leave, timer tick) and returns one result item per event, in order. An event is
// classified and its motion magnitude |dx|+|dy| computed in the front end, written into a
// short command queue, and applied by the back end, which updates the recognizer state and
// loads the result register. Sustained throughput is one item per clock while neither
// side stalls; an item is popped from the queue into the result register once that
// register is free or its result is taken. Either side can stall without blocking the
// other for up to QUEUE_DEPTH items plus the one in the result register. Configuration
// registers (index 0 hold time in ms, index 1 motion allowance in 1/16 pixel units) are
// always ready and should be written only while no item is in flight.
`default_nettype none
module long_press_detector_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lpd_pkg::FUNC_W-1:0]    func,
    input  wire logic                          is_left_button,
    input  wire logic [lpd_pkg::DELTA_W-1:0]   move_dx,
    input  wire logic [lpd_pkg::DELTA_W-1:0]   move_dy,
    input  wire logic [lpd_pkg::TIME_W-1:0]    elapsed_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               handled,
    output logic                               fired,
    output logic [lpd_pkg::PHASE_W-1:0]        fired_phase,
    output logic                               moving,
    output logic [lpd_pkg::PHASE_W-1:0]        phase_now,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpd_pkg::CFG_W-1:0]     cfg_data
);

    lpd_pkg::cmd_t              front_cmd;
    lpd_pkg::cmd_t              head_cmd;
    logic                       q_not_full;
    logic                       q_not_empty;
    logic                       q_pop;
    logic [lpd_pkg::CFG_W-1:0]  hold_time_reg;
    logic [lpd_pkg::CFG_W-1:0]  allowed_reg;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg <= lpd_pkg::HOLD_TIME_RESET;
            allowed_reg   <= lpd_pkg::ALLOWED_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lpd_pkg::CFG_HOLD_TIME)
            begin
                hold_time_reg <= cfg_data;
            end
            else if (cfg_index == lpd_pkg::CFG_ALLOWED)
            begin
                allowed_reg <= cfg_data;
            end
        end
    end

    // Event classification.
    lpd_front u_front (
        .func           (func),
        .is_left_button (is_left_button),
        .move_dx        (move_dx),
        .move_dy        (move_dy),
        .elapsed_ms     (elapsed_ms),
        .cmd            (front_cmd)
    );

    assign in_ready = q_not_full;

    // Decoupling queue.
    lpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // State update and result register.
    lpd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_not_empty),
        .cmd            (head_cmd),
        .cmd_pop        (q_pop),
        .hold_time_ms   (hold_time_reg),
        .allowed_motion (allowed_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .handled        (handled),
        .fired          (fired),
        .fired_phase    (fired_phase),
        .moving         (moving),
        .phase_now      (phase_now)
    );

    // A notification always carries a real phase and marks the item handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> handled && (fired_phase != lpd_pkg::PH_POSSIBLE))
        else $error("fired result without a phase");

    // A Changed notification leaves the recognizer moving in Changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired && (fired_phase == lpd_pkg::PH_CHANGED)
            |-> moving && (phase_now == lpd_pkg::PH_CHANGED))
        else $error("changed notification with inconsistent state");

    // The move flag is only ever set while the gesture is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moving
            |-> (phase_now == lpd_pkg::PH_BEGAN) || (phase_now == lpd_pkg::PH_CHANGED))
        else $error("moving outside an active gesture");

endmodule
`default_nettype wire

FILE: verif/long_press_detector_top_tb.sv
// Self-checking testbench for the long-press detector: random and directed event streams.
`timescale 1ns / 1ps
module long_press_detector_top_tb;
    import lpd_pkg::*;

    // Spare register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int unsigned HELD_LIMIT  = (1 << HELD_W) - 1;
    localparam int unsigned SUM_LIMIT   = (1 << SUM_W) - 1;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned MAX_REPORTS = 10;

    // One input event as it appears on the ports.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               left;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic [TIME_W-1:0]  ms;
    } touch_ev_t;

    // One result item as it appears on the ports.
    typedef struct packed {
        logic               handled;
        logic               fired;
        logic [PHASE_W-1:0] fired_phase;
        logic               moving;
        logic [PHASE_W-1:0] phase_now;
    } outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func = '0;
    logic                 is_left_button = 1'b0;
    logic [DELTA_W-1:0]   move_dx = '0;
    logic [DELTA_W-1:0]   move_dy = '0;
    logic [TIME_W-1:0]    elapsed_ms = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 handled;
    logic                 fired;
    logic [PHASE_W-1:0]   fired_phase;
    logic                 moving;
    logic [PHASE_W-1:0]   phase_now;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Handshake flags sampled at the rising edge and read at the falling edge.
    logic in_took = 1'b0;
    logic cfg_took = 1'b0;

    // Events waiting to be sent and results waiting to be seen.
    touch_ev_t event_queue[$];
    outcome_t  expected_outcomes[$];

    // Idling controls set per phase.
    int unsigned tx_gap_max = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned quiet_cycles = 0;

    // Recognizer state as predicted by the testbench.
    logic [CFG_W-1:0]  hold_cfg = HOLD_TIME_RESET;
    logic [CFG_W-1:0]  allow_cfg = ALLOWED_RESET;
    logic              rec_armed = 1'b0;
    logic [HELD_W-1:0] rec_held = '0;
    logic [SUM_W-1:0]  rec_sum = '0;
    phase_t            rec_phase = PH_POSSIBLE;
    logic              rec_moving = 1'b0;

    // The stimulus side keeps its own view of the current settings.
    int unsigned cur_hold = HOLD_TIME_RESET;
    int unsigned cur_allow = ALLOWED_RESET;

    int unsigned n_queued = 0;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_cfg = 0;
    int unsigned n_settings = 1;
    int unsigned n_errors = 0;
    int unsigned n_began = 0;
    int unsigned n_changed = 0;
    int unsigned n_ended = 0;
    int unsigned n_failed = 0;

    long_press_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .is_left_button (is_left_button),
        .move_dx        (move_dx),
        .move_dy        (move_dy),
        .elapsed_ms     (elapsed_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .handled        (handled),
        .fired          (fired),
        .fired_phase    (fired_phase),
        .moving         (moving),
        .phase_now      (phase_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Absolute value of a signed 16-bit delta; the most negative value gives 32768.
    function automatic int unsigned magnitude(input logic [DELTA_W-1:0] d);
        return d[DELTA_W-1] ? (32'd1 << DELTA_W) - 32'(d) : 32'(d);
    endfunction

    // Applies one event to the predicted recognizer state and returns its result.
    function automatic outcome_t advance_recognizer(input touch_ev_t ev);
        outcome_t    res;
        logic        active;
        int unsigned acc;
        res = '0;
        active = (rec_phase == PH_BEGAN) || (rec_phase == PH_CHANGED);
        case (ev.func)
            FUNC_PRESS:
            begin
                // Only the left button arms the gesture.
                if (ev.left)
                begin
                    rec_armed = 1'b1;
                    rec_held = '0;
                    rec_sum = '0;
                    rec_moving = 1'b0;
                    rec_phase = PH_POSSIBLE;
                end
            end
            FUNC_MOVE:
            begin
                if (rec_armed || active)
                begin
                    acc = rec_sum + magnitude(ev.dx) + magnitude(ev.dy);
                    rec_sum = SUM_W'((acc > SUM_LIMIT) ? SUM_LIMIT : acc);
                    if (active)
                    begin
                        rec_phase = PH_CHANGED;
                        rec_moving = 1'b1;
                        res.fired = 1'b1;
                        res.fired_phase = PH_CHANGED;
                        n_changed++;
                    end
                    else if (rec_sum > allow_cfg)
                    begin
                        // Too much motion before the hold time: the gesture fails silently.
                        rec_armed = 1'b0;
                        rec_held = '0;
                        rec_phase = PH_FAILED;
                        n_failed++;
                    end
                end
            end
            FUNC_RELEASE, FUNC_LEAVE:
            begin
                rec_armed = 1'b0;
                rec_held = '0;
                if (active)
                begin
                    rec_moving = 1'b0;
                    res.fired = 1'b1;
                    res.fired_phase = PH_ENDED;
                    n_ended++;
                end
                rec_phase = PH_POSSIBLE;
            end
            FUNC_TICK:
            begin
                if (rec_armed && rec_phase == PH_POSSIBLE)
                begin
                    acc = rec_held + ev.ms;
                    rec_held = HELD_W'((acc > HELD_LIMIT) ? HELD_LIMIT : acc);
                    if (rec_held >= hold_cfg)
                    begin
                        rec_armed = 1'b0;
                        rec_held = '0;
                        rec_phase = PH_BEGAN;
                        res.fired = 1'b1;
                        res.fired_phase = PH_BEGAN;
                        n_began++;
                    end
                end
            end
            default:
            begin
                // Unknown event kinds leave the state alone.
            end
        endcase
        res.handled = res.fired;
        res.moving = rec_moving;
        res.phase_now = rec_phase;
        return res;
    endfunction

    // Sender: presents queued events in bursts separated by random gaps.
    always @(negedge clk)
    begin : event_driver
        touch_ev_t ev;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (event_queue.size() != 0)
            begin
                ev = event_queue.pop_front();
                func <= ev.func;
                is_left_button <= ev.left;
                move_dx <= ev.dx;
                move_dy <= ev.dy;
                elapsed_ms <= ev.ms;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Monitor: tracks register writes, predicts each accepted event, checks each result.
    always @(posedge clk)
    begin : result_monitor
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            in_took <= 1'b0;
            cfg_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            cfg_took <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_index)
                    CFG_HOLD_TIME: hold_cfg = cfg_data;
                    CFG_ALLOWED:   allow_cfg = cfg_data;
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {handled, fired, fired_phase, moving, phase_now};
                n_results++;
                if (expected_outcomes.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: result with nothing expected: %p", got);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.handled !== want.handled || got.fired !== want.fired ||
                        got.fired_phase !== want.fired_phase ||
                        got.moving !== want.moving || got.phase_now !== want.phase_now)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("ERROR: result %0d: expected %p, got %p",
                                     n_results, want, got);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                n_items++;
                expected_outcomes.push_back(advance_recognizer(
                    {func, is_left_button, move_dx, move_dy, elapsed_ms}));
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no traffic for %0d cycles", quiet_cycles);
            $display("long_press_detector_top_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic touch_ev_t make_ev(input logic [FUNC_W-1:0] f, input logic l,
                                          input logic [DELTA_W-1:0] dx,
                                          input logic [DELTA_W-1:0] dy,
                                          input logic [TIME_W-1:0] ms);
        touch_ev_t ev;
        ev.func = f;
        ev.left = l;
        ev.dx = dx;
        ev.dy = dy;
        ev.ms = ms;
        return ev;
    endfunction

    // Any event at all, unknown kinds included.
    function automatic touch_ev_t noise_ev();
        return make_ev(FUNC_W'($urandom_range(0, 7)), 1'($urandom),
                       DELTA_W'($urandom), DELTA_W'($urandom), TIME_W'($urandom));
    endfunction

    // Motion delta sized to the current allowance, now and then over the full range.
    function automatic logic [DELTA_W-1:0] pick_delta();
        int          v;
        int unsigned span;
        span = cur_allow / 6 + 1;
        if (span > 32767)
            span = 32767;
        if ($urandom_range(0, 9) == 0)
            return DELTA_W'($urandom);
        v = int'($urandom_range(0, 2 * span)) - int'(span);
        return DELTA_W'(v);
    endfunction

    // Tick length sized to the current hold time, now and then over the full range.
    function automatic logic [TIME_W-1:0] pick_ms();
        if ($urandom_range(0, 7) == 0)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(0, cur_hold / 3 + 1));
    endfunction

    task automatic offer(input touch_ev_t ev);
        event_queue.push_back(ev);
        n_queued++;
    endtask

    // A left press, a run of ticks and moves, and usually a release or a leave.
    task automatic queue_gesture();
        int unsigned steps;
        int unsigned r;
        offer(make_ev(FUNC_PRESS, 1'b1, pick_delta(), pick_delta(), pick_ms()));
        steps = $urandom_range(1, 10);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            if (r < 48)
                offer(make_ev(FUNC_TICK, 1'($urandom), pick_delta(), pick_delta(), pick_ms()));
            else if (r < 93)
                offer(make_ev(FUNC_MOVE, 1'($urandom), pick_delta(), pick_delta(), pick_ms()));
            else
                offer(noise_ev());
        end
        r = $urandom_range(0, 99);
        if (r >= 55)
            offer(make_ev(FUNC_LEAVE, 1'($urandom), pick_delta(), pick_delta(), pick_ms()));
        else if (r >= 10)
            offer(make_ev(FUNC_RELEASE, 1'($urandom), pick_delta(), pick_delta(), pick_ms()));
    endtask

    // Mostly well-formed gestures, with some stray events between them.
    task automatic queue_random(input int unsigned count);
        int unsigned target;
        target = n_queued + count;
        while (n_queued < target)
        begin
            if ($urandom_range(0, 7) == 0)
                offer(noise_ev());
            else
                queue_gesture();
        end
    endtask

    // Waits at a falling edge until every queued event is accepted and every result seen.
    task automatic drain();
        do
            @(negedge clk);
        while (n_items != n_queued || expected_outcomes.size() != 0);
    endtask

    // Writes one register; call at a falling edge, leaves cfg_valid high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_took);
    endtask

    // Drains the block, then loads a new setting and sometimes pokes the spare indexes.
    task automatic set_config(input int unsigned hold, input int unsigned allow);
        drain();
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_HOLD_TIME, CFG_W'(hold));
        write_reg(CFG_ALLOWED, CFG_W'(allow));
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_SPARE_B, CFG_W'($urandom));
        cfg_valid <= 1'b0;
        cur_hold = hold;
        cur_allow = allow;
        n_settings++;
    endtask

    // Sets the idling of both sides for the next phase, just after a rising edge.
    task automatic start_phase(input int unsigned gaps, input int unsigned stall);
        @(posedge clk);
        tx_gap_max = gaps;
        rx_stall_pct = stall;
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed events under the reset settings (hold 2000 ms, allowance 160).
        start_phase(3, 30);
        offer(make_ev(FUNC_PRESS, 1'b0, '0, '0, '0));                  // right button: ignored
        offer(make_ev(FUNC_MOVE, 1'b0, 16'd5, 16'd5, '0));             // move while idle
        offer(make_ev(FUNC_W'(FUNC_TICK + 1), 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        offer(make_ev(FUNC_W'(FUNC_TICK + 3), 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, 16'd1000));             // tick while unarmed
        offer(make_ev(FUNC_RELEASE, 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, 16'd1000));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'd10, 16'hFFF6, '0));
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, 16'd1000));             // reaches hold: began
        // Large moves after began drive the motion sum into saturation.
        offer(make_ev(FUNC_MOVE, 1'b0, 16'h7FFF, 16'h8000, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'h8000, 16'h8000, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'h8000, 16'h7FFF, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'h8000, 16'h8000, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_LEAVE, 1'b0, '0, '0, '0));                  // ended
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'd80, 16'hFFB0, '0));         // exactly at allowance
        offer(make_ev(FUNC_MOVE, 1'b0, '0, 16'd1, '0));                // one over: failed
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, 16'hFFFF));             // disarmed: ignored
        offer(make_ev(FUNC_MOVE, 1'b0, 16'd1, 16'd1, '0));
        offer(make_ev(FUNC_RELEASE, 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, 16'hFFFF));
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));                  // re-press while began
        offer(make_ev(FUNC_RELEASE, 1'b0, '0, '0, '0));

        // Random gestures with no idling on either side.
        start_phase(0, 0);
        queue_random(120);

        // Zero hold time and zero allowance.
        set_config(0, 0);
        start_phase(4, 25);
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));
        offer(make_ev(FUNC_TICK, 1'b0, '0, '0, '0));                   // began on a zero tick
        offer(make_ev(FUNC_MOVE, 1'b0, 16'd3, '0, '0));
        offer(make_ev(FUNC_RELEASE, 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_PRESS, 1'b1, '0, '0, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, '0, '0, '0));
        offer(make_ev(FUNC_MOVE, 1'b0, 16'hFFFF, '0, '0));             // failed
        offer(make_ev(FUNC_LEAVE, 1'b0, '0, '0, '0));
        queue_random(100);

        // Largest settings, with the receiver holding off while events keep coming.
        set_config(65535, 65535);
        start_phase(0, 50);
        hold_req++;
        queue_random(120);

        // Smallest nonzero settings with long sender gaps.
        set_config(1, 1);
        start_phase(10, 20);
        hold_req++;
        queue_random(100);

        // A few random settings with varied idling.
        repeat (3)
        begin
            set_config($urandom_range(0, 5000), $urandom_range(0, 2000));
            start_phase($urandom_range(0, 6), $urandom_range(0, 60));
            queue_random(120);
        end

        drain();
        repeat (4) @(posedge clk);
        if (expected_outcomes.size() != 0)
        begin
            n_errors++;
            $display("ERROR: %0d results never arrived", expected_outcomes.size());
        end
        $display("Sent %0d events and checked %0d results across %0d settings (%0d reg writes).",
                 n_items, n_results, n_settings, n_cfg);
        $display("Gesture outcomes seen: %0d began, %0d changed, %0d ended, %0d failed.",
                 n_began, n_changed, n_ended, n_failed);
        if (n_errors == 0)
            $display("long_press_detector_top_tb OK");
        else
            $display("long_press_detector_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: long_press_detector_top.f
hdl/lpd_pkg.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/lpd_back.sv
hdl/long_press_detector_top.sv
verif/long_press_detector_top_tb.sv
